// ===== rtl/core/nsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_F   = 8'h66;

	localparam int unsigned OUT_CHARS = 5;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NO_START  = 3'd2,
		ST_NO_STAR   = 3'd3,
		ST_SHORT_SUM = 3'd4,
		ST_BAD_HEX   = 3'd5,
		ST_MISMATCH  = 3'd6
	} status_t;

	typedef enum logic {
		PH_WAIT = 1'b0,
		PH_BODY = 1'b1
	} phase_t;

	typedef struct packed {
		status_t                      status;
		logic [OUT_CHARS-1:0][7:0]    addr_chars;
		logic [3:0]                   address_length;
		logic [7:0]                   field_count;
		logic [7:0]                   computed_checksum;
		logic [7:0]                   received_checksum;
	} result_t;

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// msb flags a valid digit, low nibble is its value
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = c - CH_UC_A + 8'd10;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = c - CH_LC_A + 8'd10;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nsc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nsc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nsc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] talker_first;
	logic [7:0] talker_second;
	logic [7:0] type_char_a;
	logic [7:0] type_char_b;
	logic [7:0] type_char_c;
	logic [3:0] address_length;
	logic [7:0] field_count;
	logic [7:0] computed_checksum;
	logic [7:0] received_checksum;

	modport source (
		output valid, output status, output talker_first, output talker_second,
		output type_char_a, output type_char_b, output type_char_c,
		output address_length, output field_count, output computed_checksum,
		output received_checksum, input ready
	);
	modport sink (
		input valid, input status, input talker_first, input talker_second,
		input type_char_a, input type_char_b, input type_char_c,
		input address_length, input field_count, input computed_checksum,
		input received_checksum, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/nmea_sentence_checker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Checks NMEA 0183 sentences streamed one byte per request, last_byte set on the
// final byte. Bytes are taken at one per clock cycle, back to back; a byte passes
// an input register, updates the running XOR, comma and address trackers, and on
// the last byte the report is written to the output register as that byte leaves
// the input register. Input is held off only while a last byte waits in the
// input register and the previous report has not been taken. ADDRESS_CHARS sets
// how many leading address characters are stored; at most five are reported,
// the rest read as zero.
module nmea_sentence_checker_core import nsc_pkg::*; #(
	parameter int unsigned ADDRESS_CHARS = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nsc_in_if.sink    sentence,
	nsc_out_if.source report
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       out_free;
	logic       advance;

	assign out_free       = !out_valid_q || report.ready;
	assign advance        = valid_s1 && (!last_s1 || out_free);
	assign sentence.ready = !valid_s1 || !last_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sentence.ready) begin
			valid_s1 <= sentence.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sentence.ready && sentence.valid) begin
			byte_s1 <= sentence.data_byte;
			last_s1 <= sentence.last_byte;
		end
	end

	nsc_tracker #(
		.ADDRESS_CHARS(ADDRESS_CHARS)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			res_q <= res;
	end

	assign report.valid             = out_valid_q;
	assign report.status            = res_q.status;
	assign report.talker_first      = res_q.addr_chars[0];
	assign report.talker_second     = res_q.addr_chars[1];
	assign report.type_char_a       = res_q.addr_chars[2];
	assign report.type_char_b       = res_q.addr_chars[3];
	assign report.type_char_c       = res_q.addr_chars[4];
	assign report.address_length    = res_q.address_length;
	assign report.field_count       = res_q.field_count;
	assign report.computed_checksum = res_q.computed_checksum;
	assign report.received_checksum = res_q.received_checksum;

`ifndef NO_ASSERTIONS
	a_report_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> report.valid)
		else $error("report not raised after last byte");

	a_held_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !out_free |=> valid_s1 && last_s1 && $stable(byte_s1))
		else $error("stalled last byte lost from input register");

	a_error_no_fields: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && report.status != ST_OK
		|-> report.address_length == 4'd0 && report.field_count == 8'd0)
		else $error("address fields reported with error status");

	a_early_error_no_sum: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && (report.status == ST_EMPTY || report.status == ST_NO_START
		|| report.status == ST_NO_STAR)
		|-> report.computed_checksum == 8'd0 && report.received_checksum == 8'd0)
		else $error("checksum reported before a star was seen");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nsc_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsc_tracker import nsc_pkg::*; #(
	parameter int unsigned ADDRESS_CHARS = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output result_t         result
);

	phase_t     phase_q, phase_n;
	logic       start_ok_q, start_ok_n;
	logic [7:0] run_xor_q, run_xor_n;
	logic       star_seen_q, star_seen_n;
	logic [7:0] star_xor_q, star_xor_n;
	logic [7:0] comma_q, comma_n;
	logic [7:0] star_comma_q, star_comma_n;
	logic       nonempty_q, nonempty_n;
	logic       star_nonempty_q, star_nonempty_n;
	logic [3:0] addr_len_q, addr_len_n;
	logic [3:0] star_addr_len_q, star_addr_len_n;
	logic [1:0] after_cnt_q, after_cnt_n;
	logic [1:0] after_trim_q, after_trim_n;
	logic [7:0] hex_high_q, hex_high_n;
	logic [7:0] hex_low_q, hex_low_n;
	logic [7:0] addr_chars_q [ADDRESS_CHARS];
	logic       addr_wr;

	logic [4:0] hv, lv;
	logic [7:0] recv;
	status_t    st;
	logic       ok;
	logic [OUT_CHARS-1:0][7:0] chars_out;

	always_comb begin
		phase_n         = phase_q;
		start_ok_n      = start_ok_q;
		run_xor_n       = run_xor_q;
		star_seen_n     = star_seen_q;
		star_xor_n      = star_xor_q;
		comma_n         = comma_q;
		star_comma_n    = star_comma_q;
		nonempty_n      = nonempty_q;
		star_nonempty_n = star_nonempty_q;
		addr_len_n      = addr_len_q;
		star_addr_len_n = star_addr_len_q;
		after_cnt_n     = after_cnt_q;
		after_trim_n    = after_trim_q;
		hex_high_n      = hex_high_q;
		hex_low_n       = hex_low_q;
		addr_wr         = 1'b0;
		if (step) begin
			case (phase_q)
				PH_WAIT: begin
					if (!is_blank(data_byte)) begin
						phase_n    = PH_BODY;
						start_ok_n = (data_byte == CH_DOLLAR) || (data_byte == CH_BANG);
					end
				end
				PH_BODY: begin
					if (data_byte == CH_STAR) begin
						star_seen_n     = 1'b1;
						star_xor_n      = run_xor_q;
						star_comma_n    = comma_q;
						star_nonempty_n = nonempty_q;
						star_addr_len_n = addr_len_q;
						after_cnt_n     = '0;
						after_trim_n    = '0;
						hex_high_n      = '0;
						hex_low_n       = '0;
					end else if (star_seen_q) begin
						if (after_cnt_q == 2'd0)
							hex_high_n = data_byte;
						else if (after_cnt_q == 2'd1)
							hex_low_n = data_byte;
						if (after_cnt_q != 2'd3)
							after_cnt_n = after_cnt_q + 2'd1;
						if (!is_blank(data_byte))
							after_trim_n = after_cnt_n;
					end
					run_xor_n = run_xor_q ^ data_byte;
					if (comma_q != 8'd0) begin
						nonempty_n = 1'b1;
					end else if (data_byte != CH_COMMA) begin
						addr_wr = 1'b1;
						if (addr_len_q != 4'd15)
							addr_len_n = addr_len_q + 4'd1;
					end
					if (data_byte == CH_COMMA && comma_q != 8'd255)
						comma_n = comma_q + 8'd1;
				end
				default: begin
					phase_n = PH_WAIT;
				end
			endcase
		end
	end

	// the last byte returns every counter to its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_WAIT;
			start_ok_q      <= 1'b0;
			run_xor_q       <= '0;
			star_seen_q     <= 1'b0;
			star_xor_q      <= '0;
			comma_q         <= '0;
			star_comma_q    <= '0;
			nonempty_q      <= 1'b0;
			star_nonempty_q <= 1'b0;
			addr_len_q      <= '0;
			star_addr_len_q <= '0;
			after_cnt_q     <= '0;
			after_trim_q    <= '0;
			hex_high_q      <= '0;
			hex_low_q       <= '0;
		end else if (step && last_byte) begin
			phase_q         <= PH_WAIT;
			start_ok_q      <= 1'b0;
			run_xor_q       <= '0;
			star_seen_q     <= 1'b0;
			star_xor_q      <= '0;
			comma_q         <= '0;
			star_comma_q    <= '0;
			nonempty_q      <= 1'b0;
			star_nonempty_q <= 1'b0;
			addr_len_q      <= '0;
			star_addr_len_q <= '0;
			after_cnt_q     <= '0;
			after_trim_q    <= '0;
			hex_high_q      <= '0;
			hex_low_q       <= '0;
		end else begin
			phase_q         <= phase_n;
			start_ok_q      <= start_ok_n;
			run_xor_q       <= run_xor_n;
			star_seen_q     <= star_seen_n;
			star_xor_q      <= star_xor_n;
			comma_q         <= comma_n;
			star_comma_q    <= star_comma_n;
			nonempty_q      <= nonempty_n;
			star_nonempty_q <= star_nonempty_n;
			addr_len_q      <= addr_len_n;
			star_addr_len_q <= star_addr_len_n;
			after_cnt_q     <= after_cnt_n;
			after_trim_q    <= after_trim_n;
			hex_high_q      <= hex_high_n;
			hex_low_q       <= hex_low_n;
		end
	end

	// entries below the snapshot length are always written in the current sentence
	always_ff @(posedge clk) begin
		for (int k = 0; k < ADDRESS_CHARS; k++) begin
			if (addr_wr && addr_len_q == 4'(k))
				addr_chars_q[k] <= data_byte;
		end
	end

	always_comb begin
		hv   = hex_value(hex_high_n);
		lv   = hex_value(hex_low_n);
		recv = {hv[3:0], lv[3:0]};
		if (phase_n == PH_WAIT)
			st = ST_EMPTY;
		else if (!start_ok_n)
			st = ST_NO_START;
		else if (!star_seen_n)
			st = ST_NO_STAR;
		else if (after_trim_n < 2'd2)
			st = ST_SHORT_SUM;
		else if (!(hv[4] && lv[4]))
			st = ST_BAD_HEX;
		else if (recv != star_xor_n)
			st = ST_MISMATCH;
		else
			st = ST_OK;
		ok = (st == ST_OK);

		result.status            = st;
		result.addr_chars        = chars_out;
		result.address_length    = ok ? star_addr_len_n : 4'd0;
		result.field_count       = (ok && star_nonempty_n) ? star_comma_n : 8'd0;
		result.computed_checksum = (ok || st == ST_SHORT_SUM || st == ST_BAD_HEX
			|| st == ST_MISMATCH) ? star_xor_n : 8'd0;
		result.received_checksum = (ok || st == ST_MISMATCH) ? recv : 8'd0;
	end

	for (genvar gi = 0; gi < OUT_CHARS; gi++) begin : g_chars
		if (gi < ADDRESS_CHARS) begin : g_kept
			assign chars_out[gi] = (ok && star_addr_len_n > 4'(gi))
				? addr_chars_q[gi] : 8'd0;
		end else begin : g_absent
			assign chars_out[gi] = 8'd0;
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_nmea_sentence_checker_core.sv =====
`timescale 1ns / 1ps

module tb_nmea_sentence_checker_core;
	import nsc_pkg::*;

	localparam int unsigned ADDR_KEEP = 5;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_UC_Z   = 8'h5A;
	localparam logic [7:0]  CH_DASH   = 8'h2D;
	localparam logic [7:0]  CH_UC_X   = 8'h58;
	localparam int          RANDOM_BYTES = 740;

	typedef enum int {
		SUM_GOOD,
		SUM_WRONG,
		SUM_SHORT,
		SUM_BADHEX,
		SUM_NONE,
		SUM_EXTRA
	} sum_flaw_t;

	typedef logic [7:0] octet_q_t[$];

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		logic       drain;
	} sent_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nsc_in_if  sentence();
	nsc_out_if report();

	nmea_sentence_checker_core #(
		.ADDRESS_CHARS(ADDR_KEEP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(sentence),
		.report(report)
	);

	always #1 clk = ~clk;

	sent_byte_t pending_bytes[$];
	result_t    expected_reports[$];
	octet_q_t   frame;
	int         body_start;
	int         sent_total;
	int         errors;

	// sentence tracker state
	phase_t     trk_phase;
	logic       start_good;
	logic [7:0] xor_acc;
	logic       star_found;
	logic [7:0] star_xor_snap;
	logic [7:0] commas;
	logic [7:0] star_commas;
	logic       data_seen;
	logic       star_data_seen;
	logic [3:0] addr_cnt;
	logic [3:0] star_addr_cnt;
	logic [7:0] addr_buf[ADDR_KEEP];
	logic [1:0] tail_cnt;
	logic [1:0] tail_trim;
	logic [7:0] sum_hi;
	logic [7:0] sum_lo;

	function automatic bit blank_char(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
		if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
		return -1;
	endfunction

	function void clear_tracker();
		trk_phase = PH_WAIT;
		start_good = 1'b0;
		xor_acc = '0;
		star_found = 1'b0;
		star_xor_snap = '0;
		commas = '0;
		star_commas = '0;
		data_seen = 1'b0;
		star_data_seen = 1'b0;
		addr_cnt = '0;
		star_addr_cnt = '0;
		for (int i = 0; i < ADDR_KEEP; i++)
			addr_buf[i] = '0;
		tail_cnt = '0;
		tail_trim = '0;
		sum_hi = '0;
		sum_lo = '0;
	endfunction

	function void track_byte(logic [7:0] c, logic fin);
		result_t    r;
		status_t    st;
		int         hv;
		int         lv;
		logic [7:0] recv;
		if (trk_phase == PH_WAIT) begin
			if (!blank_char(c)) begin
				trk_phase = PH_BODY;
				start_good = (c == CH_DOLLAR) || (c == CH_BANG);
			end
		end else begin
			if (c == CH_STAR) begin
				star_found = 1'b1;
				star_xor_snap = xor_acc;
				star_commas = commas;
				star_data_seen = data_seen;
				star_addr_cnt = addr_cnt;
				tail_cnt = '0;
				tail_trim = '0;
				sum_hi = '0;
				sum_lo = '0;
			end else if (star_found) begin
				if (tail_cnt == 2'd0)
					sum_hi = c;
				else if (tail_cnt == 2'd1)
					sum_lo = c;
				if (tail_cnt < 2'd3)
					tail_cnt++;
				if (!blank_char(c))
					tail_trim = tail_cnt;
			end
			xor_acc ^= c;
			// address runs up to the first comma, the star counts as part of it
			if (commas != 8'd0) begin
				data_seen = 1'b1;
			end else if (c != CH_COMMA) begin
				if (addr_cnt < ADDR_KEEP)
					addr_buf[addr_cnt] = c;
				if (addr_cnt < 4'd15)
					addr_cnt++;
			end
			if (c == CH_COMMA && commas < 8'd255)
				commas++;
		end
		if (!fin)
			return;

		hv = hex_nibble(sum_hi);
		lv = hex_nibble(sum_lo);
		recv = (hv >= 0 && lv >= 0) ? 8'((hv << 4) | lv) : 8'd0;
		if (trk_phase == PH_WAIT)
			st = ST_EMPTY;
		else if (!start_good)
			st = ST_NO_START;
		else if (!star_found)
			st = ST_NO_STAR;
		else if (tail_trim < 2'd2)
			st = ST_SHORT_SUM;
		else if (hv < 0 || lv < 0)
			st = ST_BAD_HEX;
		else if (recv != star_xor_snap)
			st = ST_MISMATCH;
		else
			st = ST_OK;

		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			for (int i = 0; i < OUT_CHARS; i++) begin
				if (i < ADDR_KEEP && i < int'(star_addr_cnt))
					r.addr_chars[i] = addr_buf[i];
			end
			r.address_length = star_addr_cnt;
			r.field_count = star_data_seen ? star_commas : 8'd0;
		end
		if (st == ST_OK || st >= ST_SHORT_SUM)
			r.computed_checksum = star_xor_snap;
		if (st == ST_OK || st == ST_MISMATCH)
			r.received_checksum = recv;
		expected_reports.insert(expected_reports.size(), r);
		clear_tracker();
	endfunction

	// ---------------- stimulus building ----------------

	function void put(logic [7:0] c);
		frame.insert(frame.size(), c);
	endfunction

	function void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(8'(s[i]));
	endfunction

	function logic [7:0] any_blank();
		int v;
		v = $urandom_range(0, 5);
		return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
	endfunction

	function logic [7:0] non_hex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (hex_nibble(c) >= 0 || c == CH_STAR || blank_char(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10)
			return CH_ZERO + 8'(n);
		return (lower ? CH_LC_A : CH_UC_A) + 8'(n) - 8'd10;
	endfunction

	function void send_frame(bit drain);
		sent_byte_t sb;
		for (int i = 0; i < frame.size(); i++) begin
			sb.ch = frame[i];
			sb.fin = (i == frame.size() - 1);
			sb.drain = drain && (i == 0);
			pending_bytes.insert(pending_bytes.size(), sb);
		end
		sent_total += frame.size();
		frame.delete();
	endfunction

	function void open_sentence(int lead, logic [7:0] delim);
		repeat (lead) put(any_blank());
		put(delim);
		body_start = frame.size();
	endfunction

	function void close_sentence(sum_flaw_t flaw, bit lower, int trail, bit drain);
		logic [7:0] sum;
		sum = '0;
		for (int i = body_start; i < frame.size(); i++)
			sum ^= frame[i];
		if (flaw == SUM_WRONG)
			sum ^= 8'($urandom_range(1, 255));
		case (flaw)
			SUM_GOOD, SUM_WRONG, SUM_EXTRA: begin
				put(CH_STAR);
				put(hex_char(sum[7:4], lower));
				put(hex_char(sum[3:0], lower));
				if (flaw == SUM_EXTRA)
					put(CH_UC_X);
			end
			SUM_SHORT: begin
				put(CH_STAR);
				put(hex_char(sum[7:4], lower));
			end
			SUM_BADHEX: begin
				put(CH_STAR);
				if ($urandom_range(0, 1) == 0) begin
					put(non_hex());
					put(hex_char(sum[3:0], lower));
				end else begin
					put(hex_char(sum[7:4], lower));
					put(non_hex());
				end
			end
			default: begin
			end
		endcase
		repeat (trail) put(any_blank());
		send_frame(drain);
	endfunction

	function void random_sentence(bit drain);
		int        pick;
		int        n_addr;
		sum_flaw_t flaw;
		logic [7:0] delim;
		pick = $urandom_range(0, 19);
		delim = (pick < 9) ? CH_DOLLAR : (pick < 18) ? CH_BANG : 8'($urandom_range(0, 255));
		open_sentence(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, delim);
		n_addr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : $urandom_range(2, 6);
		repeat (n_addr) begin
			if ($urandom_range(0, 7) == 0)
				put(8'($urandom_range(0, 255)));
			else
				put(8'($urandom_range(CH_UC_A, CH_UC_Z)));
		end
		repeat ($urandom_range(0, 6)) begin
			put(CH_COMMA);
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 5) == 0)
					put(8'($urandom_range(0, 255)));
				else
					put(8'($urandom_range(CH_DASH, CH_UC_Z)));
			end
		end
		pick = $urandom_range(0, 19);
		case (pick)
			13: flaw = SUM_WRONG;
			14: flaw = SUM_SHORT;
			15: flaw = SUM_BADHEX;
			16: flaw = SUM_NONE;
			17: flaw = SUM_EXTRA;
			default: flaw = SUM_GOOD;
		endcase
		close_sentence(flaw, $urandom_range(0, 1) == 1, $urandom_range(0, 2), drain);
	endfunction

	function void noise_frame(bit drain);
		repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
		send_frame(drain);
	endfunction

	// ---------------- checking ----------------

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_report();
		result_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t: unexpected report, expected none, actual status %0d",
				$time, report.status);
			errors++;
			return;
		end
		want = expected_reports.pop_front();
		compare_field("status", 8'(want.status), 8'(report.status));
		compare_field("talker_first", want.addr_chars[0], report.talker_first);
		compare_field("talker_second", want.addr_chars[1], report.talker_second);
		compare_field("type_char_a", want.addr_chars[2], report.type_char_a);
		compare_field("type_char_b", want.addr_chars[3], report.type_char_b);
		compare_field("type_char_c", want.addr_chars[4], report.type_char_c);
		compare_field("address_length", 8'(want.address_length), 8'(report.address_length));
		compare_field("field_count", want.field_count, report.field_count);
		compare_field("computed_checksum", want.computed_checksum, report.computed_checksum);
		compare_field("received_checksum", want.received_checksum, report.received_checksum);
	endfunction

	// ---------------- request driver ----------------

	sent_byte_t tx_item;
	int         tx_wait;
	bit         tx_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentence.valid <= 1'b0;
			sentence.data_byte <= '0;
			sentence.last_byte <= 1'b0;
			tx_wait = 0;
		end else begin
			if (sentence.valid && sentence.ready)
				track_byte(sentence.data_byte, sentence.last_byte);
			if (!sentence.valid || sentence.ready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					sentence.valid <= 1'b0;
				end else if (pending_bytes.size() != 0 &&
						(!pending_bytes[0].drain || expected_reports.size() == 0)) begin
					tx_item = pending_bytes.pop_front();
					sentence.valid <= 1'b1;
					sentence.data_byte <= tx_item.ch;
					sentence.last_byte <= tx_item.fin;
					if ($urandom_range(0, 47) == 0)
						tx_calm = !tx_calm;
					tx_wait = tx_calm ? 0 : $urandom_range(0, 3);
				end else begin
					sentence.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- report monitor ----------------

	int rx_wait;
	bit rx_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (report.valid && report.ready) begin
				check_report();
				if ($urandom_range(0, 31) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			report.ready <= (rx_wait == 0);
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int random_goal;
		sentence.valid = 1'b0;
		sentence.data_byte = '0;
		sentence.last_byte = 1'b0;
		report.ready = 1'b0;
		errors = 0;
		sent_total = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		clear_tracker();

		// only whitespace, then a lone delimiter
		put(CH_SPACE);
		send_frame(1'b0);
		put(CH_TAB); put(CH_LF); put(8'h0B); put(8'h0C); put(CH_CR);
		send_frame(1'b0);
		put(CH_DOLLAR);
		send_frame(1'b0);
		open_sentence(0, CH_UC_X);
		put_text("A");
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		open_sentence(1, CH_DOLLAR);
		put_text("GPGGA,1,,x");
		close_sentence(SUM_GOOD, 1'b0, 2, 1'b0);
		// lower case digits: 'J' gives 4a
		open_sentence(0, CH_BANG);
		put_text("J");
		close_sentence(SUM_GOOD, 1'b1, 0, 1'b0);
		open_sentence(0, CH_DOLLAR);
		put_text("A");
		close_sentence(SUM_SHORT, 1'b0, 1, 1'b0);
		open_sentence(0, CH_DOLLAR);
		put_text("A");
		close_sentence(SUM_BADHEX, 1'b0, 0, 1'b0);
		open_sentence(0, CH_DOLLAR);
		put_text("A");
		close_sentence(SUM_WRONG, 1'b0, 0, 1'b0);
		// address past both the kept chars and the 4-bit length
		open_sentence(0, CH_BANG);
		put_text("ABCDEFGHIJKLMNOPQ,1");
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		// comma straight before the star, then no address at all
		open_sentence(0, CH_DOLLAR);
		put_text("AB,");
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		open_sentence(0, CH_DOLLAR);
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		// earlier stars are payload, the last one counts
		open_sentence(0, CH_DOLLAR);
		put_text("A*B,C");
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		open_sentence(0, CH_DOLLAR);
		put(8'h00); put(CH_COMMA); put(8'hFF);
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b0);
		open_sentence(0, CH_DOLLAR);
		put_text("GPRMC,7");
		close_sentence(SUM_EXTRA, 1'b0, 0, 1'b0);

		random_goal = sent_total + RANDOM_BYTES;
		// field count saturation, sent once everything before it has drained
		open_sentence(0, CH_DOLLAR);
		put_text("GPX");
		repeat (260) put(CH_COMMA);
		close_sentence(SUM_GOOD, 1'b0, 0, 1'b1);
		while (sent_total < random_goal) begin
			if ($urandom_range(0, 11) == 0)
				noise_frame($urandom_range(0, 29) == 0);
			else
				random_sentence($urandom_range(0, 29) == 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || sentence.valid)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0 && expected_reports.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
